/* hw/rtl/http_request_header_parser_assert.svh */
// ----------------------------------------------------------------------------
// HTTP request header parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define HRHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hrhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Types, constants and character class helpers shared by the parser RTL.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int URI_MAX_CHARS_DEF = 63;
    localparam int URI_CNT_W         = 6;
    localparam int LEN_W             = 32;
    localparam int OUT_TDATA_W       = 56;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Match position codes; all-ones marks a mismatch
    localparam logic [2:0] METHOD_FAIL = 3'd7;
    localparam logic [2:0] GET_LEN     = 3'd3;
    localparam logic [2:0] POST_LEN    = 3'd4;
    localparam logic [4:0] KEY_FAIL    = 5'd31;
    localparam logic [4:0] KEY_LEN     = 5'd15;

    localparam logic [1:0] CRLF_LAST = 2'd3;

    typedef enum logic [3:0] {
        PH_WS_METHOD,
        PH_METHOD,
        PH_WS_URI,
        PH_URI,
        PH_WS_PROTO,
        PH_PROTO,
        PH_WS_KEY,
        PH_KEY,
        PH_WS_VALUE,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef enum logic {
        KIND_URI     = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic [7:0]           uri_byte;
        logic                 method_get;
        logic                 method_post;
        logic [URI_CNT_W-1:0] uri_length;
        logic [LEN_W-1:0]     content_length;
        logic                 length_seen;
    } hrhp_result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {["0":"9"]};
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return b inside {["0":"9"], ["A":"Z"], ["a":"z"], ":", "-", "/", "."};
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return b inside {CH_CR, CH_LF};
    endfunction

    function automatic logic [7:0] get_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = "G";
            2'd1:    c = "E";
            2'd2:    c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = "P";
            2'd1:    c = "O";
            2'd2:    c = "S";
            default: c = "T";
        endcase
        return c;
    endfunction

    // "Content-Length:"
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/hrhp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser state
// Holds the parse state and computes its update and the result for one byte.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_assert.svh"

module hrhp_parser
    import hrhp_pkg::*;
#(
    parameter int URI_MAX_CHARS = URI_MAX_CHARS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,       // consume the byte below this cycle
    input  logic [7:0]   byte_in,
    input  logic         start_req,
    output hrhp_result_t result
);

    localparam int URI_CNT_MAX = (1 << URI_CNT_W) - 1;
    localparam logic [URI_CNT_W-1:0] URI_LIMIT =
        URI_CNT_W'((URI_MAX_CHARS > URI_CNT_MAX) ? URI_CNT_MAX : URI_MAX_CHARS);

    phase_t               phase_reg,      phase_next;
    logic [2:0]           get_pos_reg,    get_pos_next;
    logic [2:0]           post_pos_reg,   post_pos_next;
    logic [4:0]           key_pos_reg,    key_pos_next;
    logic                 key_is_len_reg, key_is_len_next;
    logic [URI_CNT_W-1:0] uri_cnt_reg,    uri_cnt_next;
    logic [LEN_W-1:0]     len_val_reg,    len_val_next;
    logic                 len_found_reg,  len_found_next;
    logic [1:0]           crlf_reg,       crlf_next;

    // State as seen by this byte (cleared when it opens a new request)
    phase_t               cur_phase;
    logic [2:0]           cur_get_pos;
    logic [2:0]           cur_post_pos;
    logic [4:0]           cur_key_pos;
    logic                 cur_key_is_len;
    logic [URI_CNT_W-1:0] cur_uri_cnt;
    logic [LEN_W-1:0]     cur_len_val;
    logic                 cur_len_found;
    logic [1:0]           cur_crlf;

    logic                 tk;
    logic                 sp;
    logic                 do_value;
    logic [LEN_W+3:0]     len_acc;

    assign tk = is_token(byte_in);
    assign sp = is_ws(byte_in);

    always_comb
    begin
        if (start_req)
        begin
            cur_phase      = PH_WS_METHOD;
            cur_get_pos    = '0;
            cur_post_pos   = '0;
            cur_key_pos    = '0;
            cur_key_is_len = 1'b0;
            cur_uri_cnt    = '0;
            cur_len_val    = '0;
            cur_len_found  = 1'b0;
            cur_crlf       = '0;
        end
        else
        begin
            cur_phase      = phase_reg;
            cur_get_pos    = get_pos_reg;
            cur_post_pos   = post_pos_reg;
            cur_key_pos    = key_pos_reg;
            cur_key_is_len = key_is_len_reg;
            cur_uri_cnt    = uri_cnt_reg;
            cur_len_val    = len_val_reg;
            cur_len_found  = len_found_reg;
            cur_crlf       = crlf_reg;
        end
    end

    // Next state and result for the byte
    always_comb
    begin
        phase_next      = cur_phase;
        get_pos_next    = cur_get_pos;
        post_pos_next   = cur_post_pos;
        key_pos_next    = cur_key_pos;
        key_is_len_next = cur_key_is_len;
        uri_cnt_next    = cur_uri_cnt;
        len_val_next    = cur_len_val;
        len_found_next  = cur_len_found;
        crlf_next       = cur_crlf;
        do_value        = 1'b0;
        len_acc         = '0;
        result          = '0;

        if (cur_phase != PH_DONE)
        begin
            case (cur_phase)
                PH_WS_METHOD, PH_METHOD:
                begin
                    if (tk)
                    begin
                        phase_next = PH_METHOD;
                        if (cur_get_pos < GET_LEN && byte_in == get_char(cur_get_pos[1:0]))
                            get_pos_next = cur_get_pos + 3'd1;
                        else
                            get_pos_next = METHOD_FAIL;
                        if (cur_post_pos < POST_LEN &&
                            byte_in == post_char(cur_post_pos[1:0]))
                            post_pos_next = cur_post_pos + 3'd1;
                        else
                            post_pos_next = METHOD_FAIL;
                    end
                    else if (cur_phase == PH_METHOD || !sp)
                        phase_next = PH_WS_URI;
                end
                PH_WS_URI, PH_URI:
                begin
                    if (tk)
                    begin
                        phase_next = PH_URI;
                        if (cur_uri_cnt < URI_LIMIT)
                        begin
                            uri_cnt_next    = cur_uri_cnt + 1'b1;
                            result.valid    = 1'b1;
                            result.kind     = KIND_URI;
                            result.uri_byte = byte_in;
                        end
                    end
                    else if (cur_phase == PH_URI || !sp)
                        phase_next = PH_WS_PROTO;
                end
                PH_WS_PROTO:
                begin
                    if (tk)
                        phase_next = PH_PROTO;
                    else if (!sp)
                        phase_next = PH_WS_KEY;
                end
                PH_PROTO:
                begin
                    if (!tk)
                        phase_next = PH_WS_KEY;
                end
                PH_WS_KEY:
                begin
                    if (tk)
                    begin
                        phase_next   = PH_KEY;
                        key_pos_next = (byte_in == key_char(4'd0)) ? 5'd1 : KEY_FAIL;
                    end
                    else if (!sp)
                    begin
                        phase_next      = PH_VALUE;
                        key_is_len_next = 1'b0;
                    end
                end
                PH_KEY:
                begin
                    if (tk)
                    begin
                        if (cur_key_pos < KEY_LEN && byte_in == key_char(cur_key_pos[3:0]))
                            key_pos_next = cur_key_pos + 5'd1;
                        else
                            key_pos_next = KEY_FAIL;
                    end
                    else
                    begin
                        // key complete: exact match arms the value
                        if (cur_key_pos == KEY_LEN)
                        begin
                            key_is_len_next = 1'b1;
                            len_found_next  = 1'b1;
                            len_val_next    = '0;
                        end
                        else
                            key_is_len_next = 1'b0;
                        if (is_eol(byte_in))
                            phase_next = PH_WS_KEY;
                        else if (sp)
                            phase_next = PH_WS_VALUE;
                        else
                        begin
                            phase_next = PH_VALUE;
                            do_value   = 1'b1;
                        end
                    end
                end
                PH_WS_VALUE:
                begin
                    if (is_eol(byte_in))
                        phase_next = PH_WS_KEY;
                    else if (!sp)
                    begin
                        phase_next = PH_VALUE;
                        do_value   = 1'b1;
                    end
                end
                default:
                begin
                    if (is_eol(byte_in))
                        phase_next = PH_WS_KEY;
                    else
                    begin
                        phase_next = PH_VALUE;
                        do_value   = 1'b1;
                    end
                end
            endcase

            // Decimal accumulate, value*8 + value*2 + digit, saturating
            if (do_value && key_is_len_next)
            begin
                if (is_digit(byte_in))
                begin
                    len_acc = {1'b0, len_val_next, 3'b000} + {3'b000, len_val_next, 1'b0} +
                              {{LEN_W{1'b0}}, byte_in[3:0]};
                    len_val_next = (len_acc[LEN_W+3:LEN_W] != 4'd0) ? {LEN_W{1'b1}}
                                                                    : len_acc[LEN_W-1:0];
                end
                else
                    key_is_len_next = 1'b0;
            end

            // CR LF CR LF watch
            if (byte_in == (cur_crlf[0] ? CH_LF : CH_CR))
            begin
                if (cur_crlf == CRLF_LAST)
                begin
                    phase_next            = PH_DONE;
                    crlf_next             = '0;
                    result                = '0;
                    result.valid          = 1'b1;
                    result.kind           = KIND_SUMMARY;
                    result.method_get     = (get_pos_next == GET_LEN);
                    result.method_post    = (post_pos_next == POST_LEN);
                    result.uri_length     = uri_cnt_next;
                    result.content_length = len_val_next;
                    result.length_seen    = len_found_next;
                end
                else
                    crlf_next = cur_crlf + 2'd1;
            end
            else
                crlf_next = (byte_in == CH_CR) ? 2'd1 : 2'd0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WS_METHOD;
            get_pos_reg    <= '0;
            post_pos_reg   <= '0;
            key_pos_reg    <= '0;
            key_is_len_reg <= 1'b0;
            uri_cnt_reg    <= '0;
            len_val_reg    <= '0;
            len_found_reg  <= 1'b0;
            crlf_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            get_pos_reg    <= get_pos_next;
            post_pos_reg   <= post_pos_next;
            key_pos_reg    <= key_pos_next;
            key_is_len_reg <= key_is_len_next;
            uri_cnt_reg    <= uri_cnt_next;
            len_val_reg    <= len_val_next;
            len_found_reg  <= len_found_next;
            crlf_reg       <= crlf_next;
        end
    end

    `HRHP_ASSERT_NEXT(a_summary_ends_request, clk, rst_n,
        step && result.valid && result.kind == KIND_SUMMARY, phase_reg == PH_DONE,
        "summary item did not close the request")
    `HRHP_ASSERT_NOW(a_uri_count_limit, clk, rst_n,
        1'b1, uri_cnt_reg <= URI_LIMIT, "URI count beyond limit")
    `HRHP_ASSERT_NOW(a_length_needs_key, clk, rst_n,
        len_val_reg != '0, len_found_reg, "length value without Content-Length key")

endmodule

/* hw/rtl/http_request_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser
// Byte-stream HTTP request header parser emitting URI bytes and a summary.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tdata[7:0] request byte, tuser start of request
// m_*      out  tuser kind, tdata URI byte / method flags / URI length /
//                Content-Length value / length seen
//
// One byte per cycle sustained while m_tready does not stall; m_tvalid rises after
// the byte is taken into the input register at the s_ accept edge and the parse
// logic then writes its item into the result register once that register is free.
// A byte that causes no item leaves the result register untouched.
// Reset clears the parse state and both valid flags; no clearing pass.
// A stall on m_tready holds the result and backs up into the input register.
`include "http_request_header_parser_assert.svh"

module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int URI_MAX_CHARS = URI_MAX_CHARS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] byte_in
    input  logic                   s_tuser,   // [0] start_req
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] uri_byte, [8] method_get,
                                              // [9] method_post, [15:10] uri_length,
                                              // [47:16] content_length,
                                              // [48] length_seen, [55:49] zero
    output logic                   m_tuser    // [0] kind
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;
    logic         out_valid_reg;
    hrhp_result_t out_reg;
    hrhp_result_t result;
    logic         out_free;
    logic         step;

    // Handshake: result register frees when empty or taken
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    hrhp_parser #(
        .URI_MAX_CHARS (URI_MAX_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_byte_reg),
        .start_req (in_start_reg),
        .result    (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'b0, out_reg.length_seen, out_reg.content_length,
                       out_reg.uri_length, out_reg.method_post, out_reg.method_get,
                       out_reg.uri_byte};

    `HRHP_ASSERT_NEXT(a_input_held, clk, rst_n,
        in_valid_reg && !out_free, in_valid_reg && $stable(in_byte_reg),
        "waiting input item lost")
    `HRHP_ASSERT_NOW(a_summary_no_uri_byte, clk, rst_n,
        m_tvalid && m_tuser, m_tdata[7:0] == 8'd0, "summary item carries a URI byte")
    `HRHP_ASSERT_NOW(a_uri_item_clean, clk, rst_n,
        m_tvalid && !m_tuser, m_tdata[OUT_TDATA_W-1:8] == '0,
        "URI item carries summary fields")

endmodule
